FILE: src/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Number of waiting slots in the ready chain
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request opcodes
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // One stored task
    typedef struct packed {
        logic [7:0]  tag;
        logic [7:0]  prio;
        logic [7:0]  svc;
        logic [15:0] arr;
    } t_entry;

    // Input request
    typedef struct packed {
        logic       op;
        logic [7:0] task_tag;
        logic [7:0] task_priority;
        logic [7:0] service_length;
    } t_in_req;

    // Result
    typedef struct packed {
        logic        accepted;
        logic        cpu_busy;
        logic [7:0]  running_tag;
        logic [7:0]  running_priority;
        logic [7:0]  running_left;
        logic        done_valid;
        logic [7:0]  done_tag;
        logic [15:0] done_time;
        logic [15:0] done_response;
        logic [15:0] done_wait;
        logic [15:0] now_time;
    } t_out_res;

    // Chain control, broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: src/nps_cell.sv
// ----------------------------------------------------------------------------
// nps_cell
// One slot of the sorted ready chain: holds an entry, compares it against an
// arriving task and shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module nps_cell (
    input  logic               i_clk,
    input  nps_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  nps_pkg::t_entry    i_new,
    input  nps_pkg::t_entry    i_prev,
    input  logic               i_prev_before,
    input  nps_pkg::t_entry    i_next,
    output nps_pkg::t_entry    o_entry,
    output logic               o_before
);
    import nps_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Stored entry sorts ahead of the new one: lower priority number, or equal
    // priority with strictly longer service
    always_comb begin
        if (r_entry.prio != i_new.prio) begin
            o_before = i_occupied && (r_entry.prio < i_new.prio);
        end else begin
            o_before = i_occupied && (r_entry.svc > i_new.svc);
        end
    end

    // Keep, take the upstream neighbor, take the new entry, or pull from below
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (o_before) begin
                n_entry = r_entry;
            end else if (!i_prev_before) begin
                n_entry = i_prev;
            end else begin
                n_entry = i_new;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: src/nonpreemptive_priority_scheduler_top.sv
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_top
// Non-preemptive priority scheduler with a sorted chain of ready slots.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with payload i_in_req. An
//   arrival request (op = arrival) inserts a task into the sorted ready chain,
//   stamped with the current time; it is refused when all QUEUE_DEPTH slots
//   are full. A tick request dispatches, completes or runs the current task
//   and then advances the 16-bit time counter.
//   Every request yields exactly one result on o_out_valid / i_out_ready with
//   payload o_out_res, in the cycle after the request is taken.
//   Throughput is one request per cycle unless the receiver stalls: the chain
//   inserts (each slot compares with the new task and shifts tailward) or pops.
//   A result that waits in the output register still lets a new request in
//   when the receiver takes the old one in the same cycle; while the receiver
//   stalls, o_in_ready stays low and the result holds.
//   Reset (i_rst_n low, synchronous) empties the chain, idles the cpu and
//   clears the time counter; the block takes requests on the next cycle.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nps_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nps_pkg::t_out_res o_out_res
);
    import nps_pkg::*;

    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_run_valid, n_run_valid;
    t_entry           r_run,       n_run;
    logic [7:0]       r_left,      n_left;
    logic [15:0]      r_time,      n_time;
    logic             r_out_valid;
    t_out_res         r_res,       n_res;

    t_cell_ctl        w_ctl;
    t_entry           w_new;
    t_entry           w_entry  [QUEUE_DEPTH];
    logic             w_before [QUEUE_DEPTH];
    logic             w_fire;
    logic             w_disp;
    t_entry           w_head;
    logic [15:0]      w_resp;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_fire      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    // Build the arriving entry
    assign w_new.tag  = i_in_req.task_tag;
    assign w_new.prio = i_in_req.task_priority;
    assign w_new.svc  = i_in_req.service_length;
    assign w_new.arr  = r_time;
    assign w_head     = w_entry[0];
    assign w_resp     = r_time - r_run.arr;

    // Ready chain
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_before;
        t_entry w_next;

        if (g == 0) begin : g_first
            assign w_prev        = w_new;
            assign w_prev_before = 1'b1;
        end else begin : g_mid
            assign w_prev        = w_entry[g-1];
            assign w_prev_before = w_before[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        nps_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (r_count > CNT_W'(g)),
            .i_new         (w_new),
            .i_prev        (w_prev),
            .i_prev_before (w_prev_before),
            .i_next        (w_next),
            .o_entry       (w_entry[g]),
            .o_before      (w_before[g])
        );
    end

    // Decide the request's effect on the chain, the cpu and the clock
    always_comb begin
        n_count     = r_count;
        n_run_valid = r_run_valid;
        n_run       = r_run;
        n_left      = r_left;
        n_time      = r_time;
        n_res       = '0;
        w_ctl       = '0;
        w_disp      = 1'b0;
        n_res.now_time = r_time;

        if (w_fire) begin
            if (i_in_req.op == OP_ARRIVAL) begin
                if (r_count != CNT_W'(QUEUE_DEPTH)) begin
                    w_ctl.insert   = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                    n_res.accepted = 1'b1;
                end
            end else begin
                if (!r_run_valid) begin
                    w_disp = 1'b1;
                end else if (r_left == 8'd0) begin
                    n_res.done_valid    = 1'b1;
                    n_res.done_tag      = r_run.tag;
                    n_res.done_time     = r_time;
                    n_res.done_response = w_resp;
                    n_res.done_wait     = w_resp - {8'd0, r_run.svc};
                    w_disp              = 1'b1;
                end else begin
                    n_res.cpu_busy         = 1'b1;
                    n_res.running_tag      = r_run.tag;
                    n_res.running_priority = r_run.prio;
                    n_res.running_left     = r_left;
                    n_left                 = r_left - 8'd1;
                end

                // Dispatch the head task and run its first unit, or idle the cpu if the chain is empty
                if (w_disp) begin
                    if (r_count != '0) begin
                        w_ctl.pop              = 1'b1;
                        n_count                = r_count - CNT_W'(1);
                        n_run_valid            = 1'b1;
                        n_run                  = w_head;
                        n_res.cpu_busy         = 1'b1;
                        n_res.running_tag      = w_head.tag;
                        n_res.running_priority = w_head.prio;
                        n_res.running_left     = w_head.svc;
                        n_left = (w_head.svc != 8'd0) ? (w_head.svc - 8'd1) : 8'd0;
                    end else begin
                        n_run_valid = 1'b0;
                        n_run       = '0;
                    end
                end
                n_time = r_time + 16'd1;
            end
        end
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_run_valid <= 1'b0;
            r_run       <= '0;
            r_left      <= '0;
            r_time      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_run_valid <= n_run_valid;
            r_run       <= n_run;
            r_left      <= n_left;
            r_time      <= n_time;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= n_res;
        end
    end

endmodule
